[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the cave smoothing RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define CHECK_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define CHECK_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/cas_pkg.sv]
// ---------------------------------------------------------------------------
// cas_pkg
// Types and constants of the cave smoothing pass.
// ---------------------------------------------------------------------------
package cas_pkg;

  localparam int ROW_BITS   = 64;
  localparam int WIDTH_BITS = 7;
  localparam int THR_BITS   = 4;
  localparam int CNT_W      = 4;
  localparam int CFG_BITS   = 7;
  localparam int INDEX_BITS = 2;

  localparam logic [INDEX_BITS-1:0] REG_ROW_WIDTH   = 2'd0;
  localparam logic [INDEX_BITS-1:0] REG_STAY_THR    = 2'd1;
  localparam logic [INDEX_BITS-1:0] REG_BECOME_THR  = 2'd2;

  localparam logic [WIDTH_BITS-1:0] RESET_ROW_WIDTH = 7'd64;
  localparam logic [THR_BITS-1:0]   RESET_THR       = 4'd4;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int FILL_BITS  = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [ROW_BITS-1:0] row_cells;
    logic                final_row;
  } row_item_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] new_row_cells;
    logic                final_out;
  } result_item_t;

  typedef struct packed {
    logic [1:0]   count;
    result_item_t first;
    result_item_t second;
  } push_t;

endpackage

[rtl/core/cas_lane.sv]
// ---------------------------------------------------------------------------
// cas_lane
// One cell: neighbor count and the stay or become decision.
// ---------------------------------------------------------------------------
module cas_lane
  import cas_pkg::*;
(
  input  logic [2:0]          up,
  input  logic [2:0]          mid,
  input  logic [2:0]          down,
  input  logic                active,
  input  logic [THR_BITS-1:0] stay_threshold,
  input  logic [THR_BITS-1:0] become_threshold,
  output logic                cell_next
);

  logic [CNT_W-1:0]    neighbors;
  logic [THR_BITS-1:0] thr;

  assign neighbors = CNT_W'(up[0]) + CNT_W'(up[1]) + CNT_W'(up[2])
                   + CNT_W'(mid[0]) + CNT_W'(mid[2])
                   + CNT_W'(down[0]) + CNT_W'(down[1]) + CNT_W'(down[2]);
  assign thr       = mid[1] ? stay_threshold : become_threshold;
  assign cell_next = active && (neighbors > thr);

endmodule

[rtl/core/cas_smooth.sv]
// ---------------------------------------------------------------------------
// cas_smooth
// One lane per column; the lane results merge into the smoothed row.
// ---------------------------------------------------------------------------
module cas_smooth
  import cas_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0]      up,
  input  logic [WIDTH-1:0]      mid,
  input  logic [WIDTH-1:0]      down,
  input  logic [WIDTH_BITS-1:0] row_width,
  input  logic [THR_BITS-1:0]   stay_threshold,
  input  logic [THR_BITS-1:0]   become_threshold,
  output logic [WIDTH-1:0]      smoothed
);

  logic [WIDTH-1:0] active;
  logic [WIDTH+1:0] up_pad;
  logic [WIDTH+1:0] mid_pad;
  logic [WIDTH+1:0] down_pad;

  for (genvar x = 0; x < WIDTH; x++) begin : g_mask
    assign active[x] = WIDTH_BITS'(x) < row_width;
  end

  assign up_pad   = {1'b0, up & active, 1'b0};
  assign mid_pad  = {1'b0, mid & active, 1'b0};
  assign down_pad = {1'b0, down & active, 1'b0};

  for (genvar x = 0; x < WIDTH; x++) begin : g_lane
    cas_lane u_lane (
      .up               (up_pad[x+2:x]),
      .mid              (mid_pad[x+2:x]),
      .down             (down_pad[x+2:x]),
      .active           (active[x]),
      .stay_threshold   (stay_threshold),
      .become_threshold (become_threshold),
      .cell_next        (smoothed[x])
    );
  end

endmodule

[rtl/core/cas_result_fifo.sv]
// ---------------------------------------------------------------------------
// cas_result_fifo
// Result queue taking up to two items per cycle, one out while result_ready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cas_result_fifo
  import cas_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  push_t        push,
  output logic         room,
  output logic         result_valid,
  input  logic         result_ready,
  output result_item_t result
);

  result_item_t         mem [FIFO_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [FILL_BITS-1:0] fill;
  logic                 pop;

  assign pop          = result_valid && result_ready;
  assign result_valid = fill != '0;
  assign result       = mem[rd_ptr];
  assign room         = fill <= FILL_BITS'(FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PTR_BITS'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push.count);
      rd_ptr <= rd_ptr + PTR_BITS'(pop);
      fill   <= fill + FILL_BITS'(push.count) - FILL_BITS'(pop);
    end
  end

  `CHECK_CLK_RST(a_fill_bound, clk, rst, fill <= FILL_BITS'(FIFO_DEPTH), "fifo fill beyond depth")
  `CHECK_CLK_RST(a_push_fits, clk, rst,
    push.count != 2'd0 |-> (fill + FILL_BITS'(push.count)) <= FILL_BITS'(FIFO_DEPTH),
    "fifo overflow")

endmodule

[rtl/core/cave_automaton_smoothing_pass.sv]
// ---------------------------------------------------------------------------
// cave_automaton_smoothing_pass
// One smoothing pass of a two-state cave automaton, one bitmap row per item.
//
//   channel   direction  handshake                 payload
//   row       in         row_valid / row_ready     row_item_t
//   result    out        result_valid / result_ready result_item_t
//   cfg       in         cfg_we                    cfg_index, cfg_data
//
// One row item per cycle; both smoothed rows of an item come from two
// banks of MAX_WIDTH lanes in the accepting cycle and go to the four-entry
// result queue. A final row yields two items if a row is held, else one;
// the queue drains one per cycle while result_ready is high. row_ready
// drops when the queue cannot take two more items. Reset is synchronous and
// clears the held rows, the queue and the registers to their defaults.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cave_automaton_smoothing_pass
  import cas_pkg::*;
#(
  parameter int MAX_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  input  logic                  row_valid,
  output logic                  row_ready,
  input  row_item_t             row,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_item_t          result
);

  logic [WIDTH_BITS-1:0] row_width;
  logic [THR_BITS-1:0]   stay_threshold;
  logic [THR_BITS-1:0]   become_threshold;
  logic [MAX_WIDTH-1:0]  row_above;
  logic [MAX_WIDTH-1:0]  row_middle;
  logic                  row_held;

  logic [MAX_WIDTH-1:0]  row_in;
  logic [MAX_WIDTH-1:0]  body_row;
  logic [MAX_WIDTH-1:0]  tail_up;
  logic [MAX_WIDTH-1:0]  tail_row;
  logic                  accept;
  push_t                 push;

  assign accept = row_valid && row_ready;
  assign row_in = row.row_cells[MAX_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width        <= RESET_ROW_WIDTH;
      stay_threshold   <= RESET_THR;
      become_threshold <= RESET_THR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_WIDTH:  row_width        <= cfg_data;
        REG_STAY_THR:   stay_threshold   <= cfg_data[THR_BITS-1:0];
        REG_BECOME_THR: become_threshold <= cfg_data[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_held   <= 1'b0;
      row_above  <= '0;
      row_middle <= '0;
    end else if (accept) begin
      if (row.final_row) begin
        row_held   <= 1'b0;
        row_above  <= '0;
        row_middle <= '0;
      end else begin
        row_held   <= 1'b1;
        row_above  <= row_held ? row_middle : '0;
        row_middle <= row_in;
      end
    end
  end

  assign tail_up = row_held ? row_middle : '0;

  cas_smooth #(.WIDTH(MAX_WIDTH)) u_body (
    .up               (row_above),
    .mid              (row_middle),
    .down             (row_in),
    .row_width        (row_width),
    .stay_threshold   (stay_threshold),
    .become_threshold (become_threshold),
    .smoothed         (body_row)
  );

  cas_smooth #(.WIDTH(MAX_WIDTH)) u_tail (
    .up               (tail_up),
    .mid              (row_in),
    .down             ('0),
    .row_width        (row_width),
    .stay_threshold   (stay_threshold),
    .become_threshold (become_threshold),
    .smoothed         (tail_row)
  );

  always_comb begin
    push = '0;
    if (accept) begin
      if (row_held) begin
        push.count                = row.final_row ? 2'd2 : 2'd1;
        push.first.new_row_cells  = ROW_BITS'(body_row);
        push.first.final_out      = 1'b0;
        push.second.new_row_cells = ROW_BITS'(tail_row);
        push.second.final_out     = 1'b1;
      end else begin
        push.count               = row.final_row ? 2'd1 : 2'd0;
        push.first.new_row_cells = ROW_BITS'(tail_row);
        push.first.final_out     = 1'b1;
      end
    end
  end

  cas_result_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room         (row_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  `CHECK_CLK_RST(a_final_clears, clk, rst,
    accept && row.final_row |=> !row_held && row_middle == '0, "final row left state held")
  `CHECK_CLK_RST(a_row_holds, clk, rst,
    accept && !row.final_row |=> row_held, "non-final row not held")
  `CHECK_CLK_RST(a_push_on_accept, clk, rst,
    push.count != 2'd0 |-> accept, "result pushed without an item")

endmodule
